[rtl/parachute_deploy_sequencer_top_defines.svh]
// Assertion macros shared by the parachute deploy sequencer RTL.
`ifndef PARACHUTE_DEPLOY_SEQUENCER_TOP_DEFINES_SVH
`define PARACHUTE_DEPLOY_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define PDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define PDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pds_pkg.sv]
// Shared types, codes and reset constants of the parachute deploy sequencer.
package pds_pkg;

	localparam int PDS_TIMER_WIDTH = 16;
	localparam int CFG_ADDR_W      = 5;
	localparam int CFG_DATA_W      = 32;

	// Register reset values
	localparam logic [9:0]  RST_BATTERY_THRESHOLD = 10'd810;
	localparam logic [7:0]  RST_ARMED_POSITION    = 8'd31;
	localparam logic [7:0]  RST_DEPLOY_POSITION   = 8'd16;
	localparam logic [15:0] RST_SERVO_HOLD_TICKS  = 16'd1500;
	localparam logic [15:0] RST_CONFIRM_TICKS     = 16'd1000;
	localparam logic [15:0] RST_PAUSE_TICKS       = 16'd500;
	localparam logic [15:0] RST_FAULT_BLINK_TICKS = 16'd100;
	localparam logic [7:0]  RST_REARM_CHECKS      = 8'd10;

	// Register index (word address)
	typedef enum logic [2:0] {
		REG_BATTERY_THRESHOLD = 3'd0,
		REG_ARMED_POSITION    = 3'd1,
		REG_DEPLOY_POSITION   = 3'd2,
		REG_SERVO_HOLD_TICKS  = 3'd3,
		REG_CONFIRM_TICKS     = 3'd4,
		REG_PAUSE_TICKS       = 3'd5,
		REG_FAULT_BLINK_TICKS = 3'd6,
		REG_REARM_CHECKS      = 3'd7
	} reg_idx_t;

	// Reported mode
	typedef enum logic [1:0] {
		MODE_ARMING = 2'd0,
		MODE_WAITING = 2'd1,
		MODE_DEPLOY = 2'd2,
		MODE_FAULT  = 2'd3
	} mode_t;

	// Sequencer phase
	typedef enum logic [3:0] {
		PH_STARTUP   = 4'd0,
		PH_ARM_HOLD  = 4'd1,
		PH_WAIT      = 4'd2,
		PH_CONFIRM   = 4'd3,
		PH_DEP_HOLD  = 4'd4,
		PH_PAUSE     = 4'd5,
		PH_CHECK     = 4'd6,
		PH_BLINK_ON  = 4'd7,
		PH_BLINK_OFF = 4'd8,
		PH_REARM     = 4'd9,
		PH_FAULT_ON  = 4'd10,
		PH_FAULT_OFF = 4'd11
	} phase_t;

	typedef struct packed {
		logic [9:0]  battery_threshold;
		logic [7:0]  armed_position;
		logic [7:0]  deploy_position;
		logic [15:0] servo_hold_ticks;
		logic [15:0] confirm_ticks;
		logic [15:0] pause_ticks;
		logic [15:0] fault_blink_ticks;
		logic [7:0]  rearm_checks;
	} cfg_t;

	typedef struct packed {
		logic       relay_on;
		logic       led_on;
		logic       pwm_enabled;
		logic [7:0] servo_position;
		mode_t      mode_code;
	} res_t;

endpackage

[rtl/parachute_deploy_sequencer_top.sv]
// Parachute deploy sequencer: input stage, sequencer core, result register.
//
// One input word per millisecond tick on the in channel (trigger_line,
// battery_level); one result word per input word on the out channel
// (relay_on, led_on, pwm_enabled, servo_position, mode_code).
// A word is taken at a rising edge with valid high and stall low.
// A taken word passes through the input stage register and then the result
// register, which presents it on out (out_valid high from then).
// Throughput: one word per cycle while out_stall is low; the state update is a
// single pass of the sequencer logic between the input stage and the result register.
// When out_stall holds, the result word stays put; the input stage still
// takes one more word and then raises in_stall until the result drains.
// Configuration is written through the APB-style port at 4*index; writes
// must only be issued while no word is in flight.
// Reset (arst_n low) loads the register defaults, returns the sequencer
// to the startup battery check and empties both stages.
`include "parachute_deploy_sequencer_top_defines.svh"
module parachute_deploy_sequencer_top import pds_pkg::*; #(
	parameter int TIMER_WIDTH = PDS_TIMER_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  trigger_line,
	input  logic [9:0]            battery_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  relay_on,
	output logic                  led_on,
	output logic                  pwm_enabled,
	output logic [7:0]            servo_position,
	output logic [1:0]            mode_code,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t       cfg;
	res_t       res, res_s2;
	logic       valid_s1, valid_s2, adv;
	logic       trigger_s1;
	logic [9:0] level_s1;

	pds_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pds_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.trigger_line  (trigger_s1),
		.battery_level (level_s1),
		.cfg           (cfg),
		.res           (res)
	);

	// Stage 1 word moves on when the result register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			trigger_s1 <= trigger_line;
			level_s1   <= battery_level;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign relay_on       = res_s2.relay_on;
	assign led_on         = res_s2.led_on;
	assign pwm_enabled    = res_s2.pwm_enabled;
	assign servo_position = res_s2.servo_position;
	assign mode_code      = res_s2.mode_code;

	// Input back-pressure only arises from a full, stalled result register
	`PDS_ASSERT_NOW(a_stall_cause, in_stall, (valid_s2 && out_stall), "input stalled without output back-pressure")
	`PDS_ASSERT_NEXT(a_adv_loads, adv, valid_s2, "advanced word not in result register")

endmodule

[rtl/pds_cfg_regs.sv]
// APB-style configuration register file of the parachute deploy sequencer.
module pds_cfg_regs import pds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.battery_threshold <= RST_BATTERY_THRESHOLD;
			cfg_q.armed_position    <= RST_ARMED_POSITION;
			cfg_q.deploy_position   <= RST_DEPLOY_POSITION;
			cfg_q.servo_hold_ticks  <= RST_SERVO_HOLD_TICKS;
			cfg_q.confirm_ticks     <= RST_CONFIRM_TICKS;
			cfg_q.pause_ticks       <= RST_PAUSE_TICKS;
			cfg_q.fault_blink_ticks <= RST_FAULT_BLINK_TICKS;
			cfg_q.rearm_checks      <= RST_REARM_CHECKS;
		end else if (wr_en) begin
			case (idx)
				REG_BATTERY_THRESHOLD: cfg_q.battery_threshold <= pwdata[9:0];
				REG_ARMED_POSITION:    cfg_q.armed_position    <= pwdata[7:0];
				REG_DEPLOY_POSITION:   cfg_q.deploy_position   <= pwdata[7:0];
				REG_SERVO_HOLD_TICKS:  cfg_q.servo_hold_ticks  <= pwdata[15:0];
				REG_CONFIRM_TICKS:     cfg_q.confirm_ticks     <= pwdata[15:0];
				REG_PAUSE_TICKS:       cfg_q.pause_ticks       <= pwdata[15:0];
				REG_FAULT_BLINK_TICKS: cfg_q.fault_blink_ticks <= pwdata[15:0];
				REG_REARM_CHECKS:      cfg_q.rearm_checks      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		case (idx)
			REG_BATTERY_THRESHOLD: prdata = CFG_DATA_W'(cfg_q.battery_threshold);
			REG_ARMED_POSITION:    prdata = CFG_DATA_W'(cfg_q.armed_position);
			REG_DEPLOY_POSITION:   prdata = CFG_DATA_W'(cfg_q.deploy_position);
			REG_SERVO_HOLD_TICKS:  prdata = CFG_DATA_W'(cfg_q.servo_hold_ticks);
			REG_CONFIRM_TICKS:     prdata = CFG_DATA_W'(cfg_q.confirm_ticks);
			REG_PAUSE_TICKS:       prdata = CFG_DATA_W'(cfg_q.pause_ticks);
			REG_FAULT_BLINK_TICKS: prdata = CFG_DATA_W'(cfg_q.fault_blink_ticks);
			REG_REARM_CHECKS:      prdata = CFG_DATA_W'(cfg_q.rearm_checks);
			default:               prdata = '0;
		endcase
	end

endmodule

[rtl/pds_core.sv]
// Sequencer state machine: phase, timer, high count and servo value per tick.
`include "parachute_deploy_sequencer_top_defines.svh"
module pds_core import pds_pkg::*; #(
	parameter int TIMER_WIDTH = PDS_TIMER_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       trigger_line,
	input  logic [9:0] battery_level,
	input  cfg_t       cfg,
	output res_t       res
);

	// Comparison width covers both the timer and the 16-bit duration registers
	localparam int LW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
	localparam logic [LW-1:0] TMAX = LW'({TIMER_WIDTH{1'b1}});

	phase_t                 phase_q, phase_n;
	logic [TIMER_WIDTH-1:0] timer_q, timer_n, timer_inc;
	logic [7:0]             high_q, high_n;
	logic [7:0]             servo_q, servo_n;
	logic [15:0]            dur;
	logic [LW-1:0]          lim, timer_ext;
	logic                   done, last_tick, low;

	// Duration as the timer sees it: zero acts as one, cut to the timer range
	function automatic logic [LW-1:0] lim_of(input logic [15:0] len);
		logic [LW-1:0] l;
		l = (len == 16'd0) ? LW'(1) : LW'(len);
		if (l > TMAX)
			l = TMAX;
		return l;
	endfunction

	assign low       = !trigger_line;
	assign timer_ext = LW'(timer_q);
	assign timer_inc = timer_q + TIMER_WIDTH'(1);

	// Duration register that applies to the current phase
	always_comb begin
		case (phase_q)
			PH_ARM_HOLD, PH_REARM, PH_DEP_HOLD:     dur = cfg.servo_hold_ticks;
			PH_CONFIRM:                             dur = cfg.confirm_ticks;
			PH_PAUSE, PH_BLINK_ON, PH_BLINK_OFF:    dur = cfg.pause_ticks;
			PH_FAULT_ON, PH_FAULT_OFF:              dur = cfg.fault_blink_ticks;
			default:                                dur = cfg.pause_ticks;
		endcase
	end

	assign lim       = lim_of(dur);
	assign done      = timer_ext >= lim;
	assign last_tick = timer_ext >= (lim - LW'(1));

	// Next state
	always_comb begin
		phase_n = phase_q;
		timer_n = timer_q;
		high_n  = high_q;
		servo_n = servo_q;
		case (phase_q)
			PH_STARTUP: begin
				timer_n = TIMER_WIDTH'(1);
				if (battery_level < cfg.battery_threshold) begin
					phase_n = PH_FAULT_ON;
				end else begin
					phase_n = PH_ARM_HOLD;
					servo_n = cfg.armed_position;
				end
			end
			PH_ARM_HOLD, PH_REARM: begin
				if (done) begin
					high_n  = '0;
					phase_n = PH_WAIT;
					timer_n = '0;
				end else begin
					timer_n = timer_inc;
				end
			end
			PH_WAIT: begin
				if (low) begin
					phase_n = PH_CONFIRM;
					timer_n = '0;
				end
			end
			PH_CONFIRM: begin
				// the last sample of the window decides
				if (last_tick) begin
					if (low) begin
						servo_n = cfg.deploy_position;
						phase_n = PH_DEP_HOLD;
						timer_n = TIMER_WIDTH'(1);
					end else begin
						phase_n = PH_WAIT;
						timer_n = '0;
					end
				end else begin
					timer_n = timer_inc;
				end
			end
			PH_DEP_HOLD: begin
				if (done) begin
					phase_n = PH_PAUSE;
					timer_n = TIMER_WIDTH'(1);
				end else begin
					timer_n = timer_inc;
				end
			end
			PH_PAUSE, PH_BLINK_OFF: begin
				if (done) begin
					phase_n = PH_CHECK;
					timer_n = '0;
				end else begin
					timer_n = timer_inc;
				end
			end
			PH_CHECK: begin
				if (low) begin
					high_n  = '0;
					phase_n = PH_BLINK_ON;
					timer_n = TIMER_WIDTH'(1);
				end else if (high_q == cfg.rearm_checks) begin
					high_n  = '0;
					servo_n = cfg.armed_position;
					phase_n = PH_REARM;
					timer_n = TIMER_WIDTH'(1);
				end else begin
					high_n = high_q + 8'd1;
				end
			end
			PH_BLINK_ON: begin
				if (done) begin
					phase_n = PH_BLINK_OFF;
					timer_n = TIMER_WIDTH'(1);
				end else begin
					timer_n = timer_inc;
				end
			end
			PH_FAULT_ON: begin
				if (done) begin
					phase_n = PH_FAULT_OFF;
					timer_n = TIMER_WIDTH'(1);
				end else begin
					timer_n = timer_inc;
				end
			end
			PH_FAULT_OFF: begin
				if (done) begin
					phase_n = PH_FAULT_ON;
					timer_n = TIMER_WIDTH'(1);
				end else begin
					timer_n = timer_inc;
				end
			end
			default: begin
				phase_n = PH_WAIT;
				timer_n = '0;
			end
		endcase
	end

	// Result fields follow the phase after this tick's update
	always_comb begin
		res.servo_position = servo_n;
		res.relay_on       = 1'b0;
		res.led_on         = 1'b0;
		case (phase_n)
			PH_STARTUP:               res.mode_code = MODE_ARMING;
			PH_ARM_HOLD: begin
				res.mode_code = MODE_ARMING;
				res.relay_on  = 1'b1;
				res.led_on    = 1'b1;
			end
			PH_WAIT, PH_CONFIRM:      res.mode_code = MODE_WAITING;
			PH_DEP_HOLD: begin
				res.mode_code = MODE_DEPLOY;
				res.relay_on  = 1'b1;
			end
			PH_REARM: begin
				res.mode_code = MODE_DEPLOY;
				res.relay_on  = 1'b1;
				res.led_on    = 1'b1;
			end
			PH_BLINK_ON: begin
				res.mode_code = MODE_DEPLOY;
				res.led_on    = 1'b1;
			end
			PH_FAULT_ON: begin
				res.mode_code = MODE_FAULT;
				res.led_on    = 1'b1;
			end
			PH_FAULT_OFF:             res.mode_code = MODE_FAULT;
			default:                  res.mode_code = MODE_DEPLOY;
		endcase
		res.pwm_enabled = res.relay_on;
	end

	// State registers, advanced once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STARTUP;
			timer_q <= '0;
			high_q  <= '0;
			servo_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			timer_q <= timer_n;
			high_q  <= high_n;
			servo_q <= servo_n;
		end
	end

	// Battery fault is permanent and never moves the servo
	`PDS_ASSERT_NEXT(a_fault_sticks, (phase_q == PH_FAULT_ON || phase_q == PH_FAULT_OFF), (phase_q == PH_FAULT_ON || phase_q == PH_FAULT_OFF), "battery fault left")
	`PDS_ASSERT_NOW(a_fault_servo_idle, (phase_q == PH_FAULT_ON || phase_q == PH_FAULT_OFF), (servo_q == 8'd0), "servo written during battery fault")

endmodule

[tb/tb_parachute_deploy_sequencer_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the parachute deploy sequencer: random ticks, APB set-up, scoreboard.
module tb_parachute_deploy_sequencer_top import pds_pkg::*; ();

	localparam int unsigned TIMER_MAX   = (1 << PDS_TIMER_WIDTH) - 1;
	localparam int          CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic       trig;
		logic [9:0] level;
	} tick_t;

	// DUT connections
	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  in_valid      = 1'b0;
	wire                   in_stall;
	logic                  trigger_line  = 1'b1;
	logic [9:0]            battery_level = '0;
	wire                   out_valid;
	logic                  out_stall     = 1'b0;
	wire                   relay_on;
	wire                   led_on;
	wire                   pwm_enabled;
	wire  [7:0]            servo_position;
	wire  [1:0]            mode_code;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr         = '0;
	logic [CFG_DATA_W-1:0] pwdata        = '0;
	wire  [CFG_DATA_W-1:0] prdata;
	wire                   pready;

	// Stimulus and scoreboard storage
	tick_t pending_ticks[$];
	res_t  awaited_outputs[$];
	tick_t next_tick;
	res_t  want;
	int    send_gap     = 0;
	int    stall_left   = 0;
	int    mismatch_cnt = 0;
	int    cycle_cnt    = 0;
	logic  calm_mode    = 1'b0;
	logic  run_level    = 1'b1;

	// Predictor state and register copy
	cfg_t        shadow_cfg;
	phase_t      seq_phase;
	int unsigned seq_timer;
	logic [7:0]  high_cnt;
	logic [7:0]  servo_pos;
	logic        last_low;

	parachute_deploy_sequencer_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.trigger_line  (trigger_line),
		.battery_level (battery_level),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.relay_on      (relay_on),
		.led_on        (led_on),
		.pwm_enabled   (pwm_enabled),
		.servo_position(servo_position),
		.mode_code     (mode_code),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Effective length of a timed phase: zero acts as one, capped by the timer
	function automatic int unsigned span_limit(input logic [15:0] len);
		int unsigned lim;
		lim = (len == 16'd0) ? 1 : len;
		if (lim > TIMER_MAX)
			lim = TIMER_MAX;
		return lim;
	endfunction

	// True once the phase has used its ticks, otherwise counts one more
	function automatic logic span_done(input logic [15:0] len);
		if (seq_timer >= span_limit(len))
			return 1'b1;
		seq_timer++;
		return 1'b0;
	endfunction

	function automatic void enter_phase(input phase_t p, input int unsigned t);
		seq_phase = p;
		seq_timer = t;
	endfunction

	// One tick of the sequencer; returns the outputs after the update
	function automatic res_t advance_sequencer(input logic trig, input logic [9:0] level);
		res_t r;
		logic low;
		logic fin;
		low = !trig;
		case (seq_phase)
		PH_STARTUP: begin
			if (level < shadow_cfg.battery_threshold) begin
				enter_phase(PH_FAULT_ON, 1);
			end else begin
				servo_pos = shadow_cfg.armed_position;
				enter_phase(PH_ARM_HOLD, 1);
			end
		end
		PH_ARM_HOLD, PH_REARM: begin
			if (span_done(shadow_cfg.servo_hold_ticks)) begin
				high_cnt = '0;
				enter_phase(PH_WAIT, 0);
			end
		end
		PH_WAIT: begin
			if (low) begin
				last_low = 1'b1;
				enter_phase(PH_CONFIRM, 0);
			end
		end
		PH_CONFIRM: begin
			// the last sample of the window decides
			last_low = low;
			fin = span_done(shadow_cfg.confirm_ticks);
			if (!fin)
				fin = seq_timer >= span_limit(shadow_cfg.confirm_ticks);
			if (fin) begin
				if (last_low) begin
					servo_pos = shadow_cfg.deploy_position;
					enter_phase(PH_DEP_HOLD, 1);
				end else begin
					enter_phase(PH_WAIT, 0);
				end
			end
		end
		PH_DEP_HOLD: begin
			if (span_done(shadow_cfg.servo_hold_ticks))
				enter_phase(PH_PAUSE, 1);
		end
		PH_PAUSE: begin
			if (span_done(shadow_cfg.pause_ticks))
				enter_phase(PH_CHECK, 0);
		end
		PH_CHECK: begin
			if (low) begin
				high_cnt = '0;
				enter_phase(PH_BLINK_ON, 1);
			end else if (high_cnt == shadow_cfg.rearm_checks) begin
				high_cnt  = '0;
				servo_pos = shadow_cfg.armed_position;
				enter_phase(PH_REARM, 1);
			end else begin
				high_cnt = high_cnt + 8'd1;
			end
		end
		PH_BLINK_ON: begin
			if (span_done(shadow_cfg.pause_ticks))
				enter_phase(PH_BLINK_OFF, 1);
		end
		PH_BLINK_OFF: begin
			if (span_done(shadow_cfg.pause_ticks))
				enter_phase(PH_CHECK, 0);
		end
		PH_FAULT_ON: begin
			if (span_done(shadow_cfg.fault_blink_ticks))
				enter_phase(PH_FAULT_OFF, 1);
		end
		PH_FAULT_OFF: begin
			if (span_done(shadow_cfg.fault_blink_ticks))
				enter_phase(PH_FAULT_ON, 1);
		end
		default: begin
			enter_phase(PH_WAIT, 0);
		end
		endcase

		r.relay_on       = seq_phase inside {PH_ARM_HOLD, PH_DEP_HOLD, PH_REARM};
		r.pwm_enabled    = r.relay_on;
		r.led_on         = seq_phase inside {PH_ARM_HOLD, PH_REARM, PH_BLINK_ON, PH_FAULT_ON};
		r.servo_position = servo_pos;
		case (seq_phase)
		PH_STARTUP, PH_ARM_HOLD: r.mode_code = MODE_ARMING;
		PH_WAIT, PH_CONFIRM:     r.mode_code = MODE_WAITING;
		PH_FAULT_ON, PH_FAULT_OFF: r.mode_code = MODE_FAULT;
		default:                 r.mode_code = MODE_DEPLOY;
		endcase
		return r;
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int pick_idle(input logic calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned exp_v, input int unsigned got_v);
		$display("ERROR @%0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
		mismatch_cnt++;
	endtask

	// APB write: setup then access; the copy follows once the access edge has passed
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
		REG_BATTERY_THRESHOLD: shadow_cfg.battery_threshold = val[9:0];
		REG_ARMED_POSITION:    shadow_cfg.armed_position    = val[7:0];
		REG_DEPLOY_POSITION:   shadow_cfg.deploy_position   = val[7:0];
		REG_SERVO_HOLD_TICKS:  shadow_cfg.servo_hold_ticks  = val[15:0];
		REG_CONFIRM_TICKS:     shadow_cfg.confirm_ticks     = val[15:0];
		REG_PAUSE_TICKS:       shadow_cfg.pause_ticks       = val[15:0];
		REG_FAULT_BLINK_TICKS: shadow_cfg.fault_blink_ticks = val[15:0];
		REG_REARM_CHECKS:      shadow_cfg.rearm_checks      = val[7:0];
		default: ;
		endcase
	endtask

	task automatic load_settings(input logic [9:0] thr, input logic [7:0] arm_pos,
			input logic [7:0] dep_pos, input logic [15:0] hold, input logic [15:0] conf,
			input logic [15:0] pause, input logic [15:0] blink, input logic [7:0] rearm);
		write_reg(REG_BATTERY_THRESHOLD, 32'(thr));
		write_reg(REG_ARMED_POSITION, 32'(arm_pos));
		write_reg(REG_DEPLOY_POSITION, 32'(dep_pos));
		write_reg(REG_SERVO_HOLD_TICKS, 32'(hold));
		write_reg(REG_CONFIRM_TICKS, 32'(conf));
		write_reg(REG_PAUSE_TICKS, 32'(pause));
		write_reg(REG_FAULT_BLINK_TICKS, 32'(blink));
		write_reg(REG_REARM_CHECKS, 32'(rearm));
		@(negedge clk);
	endtask

	// Sender holds off until every awaited word has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_ticks.size() != 0 || in_valid || awaited_outputs.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Alternating runs of trigger levels with random lengths, plus some noise
	task automatic send_runs(input int n, input logic long_highs);
		int sent;
		int len;
		tick_t t;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, 6);
				repeat (len) begin
					t.trig  = 1'($urandom_range(0, 1));
					t.level = 10'($urandom_range(0, 1023));
					pending_ticks.push_back(t);
				end
			end else begin
				run_level = !run_level;
				if (run_level && long_highs)
					len = $urandom_range(260, 320);
				else if ($urandom_range(0, 3) == 0)
					len = $urandom_range(8, 30);
				else
					len = $urandom_range(1, 8);
				repeat (len) begin
					t.trig  = run_level;
					t.level = 10'($urandom_range(0, 1023));
					pending_ticks.push_back(t);
				end
			end
			sent += len;
		end
	endtask

	// Input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// word taken at this edge: predict its result
			if (in_valid && !in_stall)
				awaited_outputs.push_back(advance_sequencer(trigger_line, battery_level));
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_ticks.size() > 0) begin
					next_tick = pending_ticks.pop_front();
					trigger_line  <= next_tick.trig;
					battery_level <= next_tick.level;
					in_valid      <= 1'b1;
					send_gap = pick_idle(calm_mode);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor and random stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_outputs.size() == 0) begin
					flag_mismatch("result word with nothing awaited, mode", 0, 32'(mode_code));
				end else begin
					want = awaited_outputs.pop_front();
					if (relay_on !== want.relay_on)
						flag_mismatch("relay_on", 32'(want.relay_on), 32'(relay_on));
					if (led_on !== want.led_on)
						flag_mismatch("led_on", 32'(want.led_on), 32'(led_on));
					if (pwm_enabled !== want.pwm_enabled)
						flag_mismatch("pwm_enabled", 32'(want.pwm_enabled), 32'(pwm_enabled));
					if (servo_position !== want.servo_position)
						flag_mismatch("servo_position", 32'(want.servo_position),
							32'(servo_position));
					if (mode_code !== want.mode_code)
						flag_mismatch("mode_code", 32'(want.mode_code), 32'(mode_code));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_idle(calm_mode);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("parachute_deploy_sequencer_top test failed");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		logic          fault_run;
		logic [0:23]   directed_trig;
		tick_t         t;

		shadow_cfg.battery_threshold = RST_BATTERY_THRESHOLD;
		shadow_cfg.armed_position    = RST_ARMED_POSITION;
		shadow_cfg.deploy_position   = RST_DEPLOY_POSITION;
		shadow_cfg.servo_hold_ticks  = RST_SERVO_HOLD_TICKS;
		shadow_cfg.confirm_ticks     = RST_CONFIRM_TICKS;
		shadow_cfg.pause_ticks       = RST_PAUSE_TICKS;
		shadow_cfg.fault_blink_ticks = RST_FAULT_BLINK_TICKS;
		shadow_cfg.rearm_checks      = RST_REARM_CHECKS;
		seq_phase = PH_STARTUP;
		seq_timer = 0;
		high_cnt  = '0;
		servo_pos = '0;
		last_low  = 1'b0;

		// the battery check happens once, so only some seeds take the fault path
		fault_run = ($urandom_range(0, 5) == 0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		load_settings(10'd512, 8'd31, 8'd16, 16'd2, 16'd3, 16'd2, 16'd2, 8'd1);

		// Directed: threshold boundary, aborted and confirmed windows, blink, re-arm
		t.trig  = 1'b1;
		t.level = fault_run ? 10'd511 : 10'd512;
		pending_ticks.push_back(t);
		directed_trig = 24'b1110_0110_0101_1110_1111_1111;
		for (int i = 0; i < 24; i++) begin
			t.trig  = directed_trig[i];
			t.level = (i == 0) ? 10'd0 : (i == 1) ? 10'd1023 : 10'($urandom_range(0, 1023));
			pending_ticks.push_back(t);
		end
		wait_drained();

		// Random phases, each with its own register set
		for (int ph = 0; ph < 8; ph++) begin
			calm_mode = (ph == 2);
			case (ph)
			0: begin
				load_settings(10'd0, 8'd255, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
			end
			1: begin
				load_settings(10'd1023, 8'd0, 8'd255, 16'($urandom_range(1, 4)),
					16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
					16'($urandom_range(1, 4)), 8'd255);
			end
			default: begin
				load_settings(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 16'($urandom_range(1, 5)),
					16'($urandom_range(1, 8)), 16'($urandom_range(1, 5)),
					16'($urandom_range(1, 5)), 8'($urandom_range(0, 6)));
			end
			endcase
			send_runs((ph == 1) ? 600 : 220, ph == 1);
			wait_drained();

			// longest durations for a while, wherever the sequencer happens to be
			if (ph == 4) begin
				write_reg(REG_SERVO_HOLD_TICKS, 32'h0000_FFFF);
				write_reg(REG_CONFIRM_TICKS, 32'h0000_FFFF);
				write_reg(REG_PAUSE_TICKS, 32'h0000_FFFF);
				write_reg(REG_FAULT_BLINK_TICKS, 32'h0000_FFFF);
				@(negedge clk);
				send_runs(30, 1'b0);
				wait_drained();
			end
		end

		repeat (10) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("parachute_deploy_sequencer_top test passed");
		else
			$display("parachute_deploy_sequencer_top test failed");
		$finish;
	end

endmodule
